// ===== src/rita_pkg.sv =====
`default_nettype none

package rita_pkg;

  // Default sizes of the converter.
  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_MAX_DIGITS = 32;

  // Fixed field widths.
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int OUT_DATA_W = ((CHAR_W + 7) / 8) * 8;

  // Radix limits and digit encoding.
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_UPPER = 7'h41;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD
  } rita_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rd_en;
    logic out_load;
  } rita_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic rd_last;
    logic out_free;
  } rita_sts_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DIGIT_TEN) begin
      res = ASCII_ZERO + CHAR_W'(d);
    end else begin
      res = ASCII_UPPER + CHAR_W'(d - DIGIT_TEN);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/radix_integer_to_ascii.sv =====
`default_nettype none

// Channel | Direction | Handshake            | Payload
// in_     | slave     | in_tvalid/in_tready   | tdata: value, radix
// out_    | master    | out_tvalid/out_tready | tdata: digit_char; tlast: last_digit
//
// Each digit comes from a full pass of the bit-serial divider over all VALUE_BITS
// bits of the value, one dividend bit per cycle. Emission then reads the digit
// memory (ST_READ) and loads the output register (ST_LOAD) for each digit; the
// load waits while the output is stalled. Words are accepted in ST_IDLE.
// A new word is accepted once the last digit sits in the output register.
// Reset (rst_n low, synchronous) returns the controller to idle and empties
// the output register; the digit memory is not cleared.

module radix_integer_to_ascii
  import rita_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire logic                                           in_tvalid,
  output logic                                                in_tready,
  // value, radix (from the lowest bit up), zero padding to whole bytes
  input  wire logic [((VALUE_BITS + RADIX_W + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                                out_tvalid,
  input  wire logic                                           out_tready,
  // digit_char, zero padding to whole bytes
  output logic [OUT_DATA_W-1:0]                               out_tdata,
  // last_digit
  output logic                                                out_tlast
);

  rita_cmd_t         cmd;
  rita_sts_t         sts;
  logic [CHAR_W-1:0] digit_char;

  rita_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rita_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_value  (in_tdata[VALUE_BITS-1:0]),
    .in_radix  (in_tdata[VALUE_BITS +: RADIX_W]),
    .out_char  (digit_char),
    .out_last  (out_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  assign out_tdata = OUT_DATA_W'(digit_char);

endmodule

`default_nettype wire

// ===== src/rita_ctrl.sv =====
`default_nettype none

module rita_ctrl
  import rita_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rita_sts_t sts,
  output rita_cmd_t      cmd
);

  rita_state_t state_r;
  rita_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.conv_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // Hold the fetched digit until the output register can take it.
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sts.rd_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/rita_dp.sv =====
`default_nettype none

module rita_dp
  import rita_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rita_cmd_t             cmd,
  output rita_sts_t                  sts,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic [RADIX_W-1:0]    in_radix,
  output logic [CHAR_W-1:0]          out_char,
  output logic                       out_last,
  output logic                       out_valid,
  input  wire logic                  out_ready
);

  localparam int BIT_W = $clog2(VALUE_BITS);
  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [VALUE_BITS-1:0] quo_r;
  logic [RADIX_W-1:0]    rem_r;
  logic [RADIX_W-1:0]    radix_r;
  logic [BIT_W-1:0]      bit_cnt_r;
  logic [CNT_W-1:0]      n_r;
  logic [IDX_W-1:0]      rd_ptr_r;
  logic [RADIX_W-1:0]    rd_data_r;
  logic                  rd_last_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;
  logic                  out_valid_r;

  logic [RADIX_W-1:0]    mem [MAX_DIGITS];

  logic [RADIX_W:0]      trial;
  logic                  q_bit;
  logic [RADIX_W-1:0]    rem_nxt;
  logic [VALUE_BITS-1:0] quo_nxt;
  logic                  bit_last;
  logic                  out_free;

  // One restoring division step: shift the next dividend bit into the remainder.
  always_comb begin
    trial    = {rem_r, quo_r[VALUE_BITS-1]};
    q_bit    = (trial >= {1'b0, radix_r});
    rem_nxt  = q_bit ? RADIX_W'(trial - {1'b0, radix_r}) : RADIX_W'(trial);
    quo_nxt  = {quo_r[VALUE_BITS-2:0], q_bit};
    bit_last = (bit_cnt_r == '0);
    out_free = !out_valid_r || out_ready;
  end

  assign sts.conv_done = bit_last &&
                         ((quo_nxt == '0) || (n_r == CNT_W'(MAX_DIGITS - 1)));
  assign sts.rd_last   = rd_last_r;
  assign sts.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r       <= '0;
      bit_cnt_r <= '0;
    end else if (cmd.load) begin
      n_r       <= '0;
      bit_cnt_r <= BIT_W'(VALUE_BITS - 1);
    end else if (cmd.div_step) begin
      if (bit_last) begin
        n_r       <= n_r + 1'b1;
        bit_cnt_r <= BIT_W'(VALUE_BITS - 1);
      end else begin
        bit_cnt_r <= bit_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_r <= '0;
    end else if (cmd.load) begin
      quo_r   <= in_value;
      rem_r   <= '0;
      radix_r <= clamp_radix(in_radix);
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      // The remainder restarts at zero for the next digit.
      rem_r <= bit_last ? '0 : rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && bit_last) begin
      mem[n_r[IDX_W-1:0]] <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_ptr_r];
      rd_last_r <= (rd_ptr_r == '0);
    end
  end

  // Digits are read back most significant first.
  always_ff @(posedge clk) begin
    if (cmd.div_step && bit_last) begin
      rd_ptr_r <= n_r[IDX_W-1:0];
    end else if (cmd.out_load) begin
      rd_ptr_r <= rd_ptr_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_char_r <= digit_to_ascii(rd_data_r);
      out_last_r <= rd_last_r;
    end
  end

  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
